// ===== src/chdec_pkg.sv =====
// chdec_pkg: shared types and constants for the chunked body decoder
// no dependencies; used by chdec_core and chunked_body_decoder_unit
package chdec_pkg;

    localparam int SIZE_BITS    = 24;
    localparam int CAP_BITS     = 18;
    localparam int CAPACITY_MAX = 131072;

    localparam logic [CAP_BITS-1:0] CAP_LIMIT = CAP_BITS'(CAPACITY_MAX + 1);
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(CAPACITY_MAX + 1);

    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       has_byte;
        logic       end_of_body;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                out_valid;
        logic                done_res;
        logic                truncated;
        logic [CAP_BITS-1:0] written_count;
    } res_item_t;

endpackage

// ===== src/chdec_core.sv =====
// chdec_core: decoder state and the single-pass step logic for one beat
// depends on chdec_pkg
module chdec_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  chdec_pkg::in_item_t          item,
    input  logic [chdec_pkg::CAP_BITS-1:0] capacity,
    output chdec_pkg::res_item_t         res,
    output logic                         res_present
);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SKIP,
        PH_DATA,
        PH_POST_CR,
        PH_POST_LF,
        PH_STOP
    } phase_t;

    localparam int SB = chdec_pkg::SIZE_BITS;
    localparam int CB = chdec_pkg::CAP_BITS;

    phase_t          phase_reg, phase_next;
    logic [SB-1:0]   accum_reg, accum_next;
    logic            saw_reg, saw_next;
    logic [SB-1:0]   remain_reg, remain_next;
    logic [CB-1:0]   written_reg, written_next;
    logic            cut_reg, cut_next;

    logic [CB-1:0]   cap_eff;
    logic            consumed;
    logic            lf_end;
    logic            emit;
    logic [4:0]      hex_val;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        return v;
    endfunction

    assign cap_eff = (capacity > chdec_pkg::CAP_LIMIT) ? chdec_pkg::CAP_LIMIT : capacity;
    assign hex_val = hex_digit(item.body_byte);

    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        saw_next     = saw_reg;
        remain_next  = remain_reg;
        written_next = written_reg;
        cut_next     = cut_reg;
        consumed     = 1'b0;
        lf_end       = 1'b0;
        emit         = 1'b0;

        if (item.has_byte)
        begin
            if (phase_reg == PH_POST_CR)
            begin
                if (item.body_byte == chdec_pkg::CH_CR)
                begin
                    phase_next = PH_POST_LF;
                    consumed   = 1'b1;
                end
                else if (item.body_byte == chdec_pkg::CH_LF)
                begin
                    phase_next = PH_SIZE;
                    consumed   = 1'b1;
                end
                else
                begin
                    phase_next = PH_SIZE;
                end
            end
            else if (phase_reg == PH_POST_LF)
            begin
                phase_next = PH_SIZE;
                consumed   = (item.body_byte == chdec_pkg::CH_LF);
            end

            if (!consumed)
            begin
                case (phase_next)
                    PH_SIZE:
                    begin
                        if (!hex_val[4])
                        begin
                            // saturate when the top nibble would shift out
                            if (accum_reg[SB-1 -: 4] != 4'd0)
                                accum_next = '1;
                            else
                                accum_next = {accum_reg[SB-5:0], hex_val[3:0]};
                            saw_next = 1'b1;
                        end
                        else if (item.body_byte != chdec_pkg::CH_LF)
                            phase_next = PH_SKIP;
                        else
                            lf_end = 1'b1;
                    end
                    PH_SKIP:
                    begin
                        lf_end = (item.body_byte == chdec_pkg::CH_LF);
                    end
                    PH_DATA:
                    begin
                        if (cap_eff != '0)
                        begin
                            if (({1'b0, written_reg} + (CB+1)'(1)) < {1'b0, cap_eff})
                            begin
                                written_next = written_reg + CB'(1);
                                emit         = 1'b1;
                            end
                            else
                                cut_next = 1'b1;
                        end
                        remain_next = remain_reg - SB'(1);
                        if (remain_reg == SB'(1))
                            phase_next = PH_POST_CR;
                    end
                    default:
                    begin
                    end
                endcase

                if (lf_end)
                begin
                    if (!saw_reg || accum_reg == '0)
                        phase_next = PH_STOP;
                    else
                    begin
                        phase_next  = PH_DATA;
                        remain_next = accum_reg;
                    end
                    accum_next = '0;
                    saw_next   = 1'b0;
                end
            end
        end

        // body end with nonzero capacity: missing chunk or short data counts as a cut
        if (item.end_of_body && cap_eff != '0)
        begin
            if ((phase_next == PH_SIZE || phase_next == PH_SKIP) && saw_next
                && accum_next != '0)
                cut_next = 1'b1;
            if (phase_next == PH_DATA)
                cut_next = 1'b1;
        end

        res.out_byte      = emit ? item.body_byte : 8'd0;
        res.out_valid     = emit;
        res.done_res      = item.end_of_body;
        res.truncated     = item.end_of_body ? cut_next : 1'b0;
        res.written_count = item.end_of_body ? written_next : '0;
        res_present       = emit || item.end_of_body;

        if (item.end_of_body)
        begin
            phase_next   = PH_SIZE;
            accum_next   = '0;
            saw_next     = 1'b0;
            remain_next  = '0;
            written_next = '0;
            cut_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIZE;
            accum_reg   <= '0;
            saw_reg     <= 1'b0;
            remain_reg  <= '0;
            written_reg <= '0;
            cut_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            saw_reg     <= saw_next;
            remain_reg  <= remain_next;
            written_reg <= written_next;
            cut_reg     <= cut_next;
        end
    end

endmodule

// ===== src/chunked_body_decoder_unit.sv =====
// chunked_body_decoder_unit: top level, input beat register, config register,
// result register; depends on chdec_pkg and chdec_core
// result path: an accepted beat is held in the input beat register, its result then in the result register
// throughput: one beat per cycle from the single-pass step; a held result beat stalls input
// reset: async active low; decoder state cleared, capacity register cap_reg set to 131073
module chunked_body_decoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [chdec_pkg::CAP_BITS-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  chdec_pkg::in_item_t            in_beat,
    output logic                           res_valid,
    input  logic                           res_stall,
    output chdec_pkg::res_item_t           res_beat
);

    logic [chdec_pkg::CAP_BITS-1:0] cap_reg;
    logic                           item_valid_reg;
    chdec_pkg::in_item_t            item_reg;
    logic                           res_valid_reg;
    chdec_pkg::res_item_t           res_reg;

    chdec_pkg::res_item_t           core_res;
    logic                           core_present;
    logic                           advance;
    logic                           accept;

    assign advance  = item_valid_reg && (!res_valid_reg || !res_stall);
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    chdec_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (item_reg),
        .capacity    (cap_reg),
        .res         (core_res),
        .res_present (core_present)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= chdec_pkg::CAP_RESET;
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;

            if (accept)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance && core_present)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_beat;
        if (advance && core_present)
            res_reg <= core_res;
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_reg;

endmodule
